// File: rtl/gcmd_pkg.sv
// ----------------------------------------------------------------------------
// gcmd_pkg
// Shared constants, types and helper functions of the grid cell membership
// update block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcmd_pkg;

	localparam int GRID_CELLS = 64;
	localparam int OBJECTS    = 256;
	localparam int CELL_W     = $clog2(GRID_CELLS);
	localparam int OBJ_W      = $clog2(OBJECTS);
	localparam int DVD_W      = 17;
	localparam int CW_W       = 12;
	localparam int CFG_W      = 16;
	localparam int IDX_W      = 3;
	localparam int BOX_HALF   = 10;
	localparam int MIN_CW     = 7;

	localparam logic [IDX_W-1:0] REG_BIAS_X     = 3'd0;
	localparam logic [IDX_W-1:0] REG_BIAS_Y     = 3'd1;
	localparam logic [IDX_W-1:0] REG_BOUND_X    = 3'd2;
	localparam logic [IDX_W-1:0] REG_BOUND_Y    = 3'd3;
	localparam logic [IDX_W-1:0] REG_CELL_WIDTH = 3'd4;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic [CELL_W-1:0] sx;
		logic [CELL_W-1:0] sy;
		logic [CELL_W-1:0] ex;
		logic [CELL_W-1:0] ey;
	} rect_t;

	localparam int RECT_W = $bits(rect_t);

	typedef struct packed {
		logic              en;
		logic              add;
		logic [CELL_W-1:0] x0;
		logic [CELL_W-1:0] x1;
		logic [CELL_W-1:0] y0;
		logic [CELL_W-1:0] y1;
	} blk_t;

	// Box corner relative to the bias, clamped, as a nonnegative dividend.
	function automatic logic [DVD_W-1:0] axis_dvd(input logic signed [15:0] loc,
			input logic signed [15:0] bias, input logic [14:0] bound, input logic is_max);
		logic signed [18:0] d;
		logic signed [18:0] v;
		logic signed [18:0] lim;
		d = 19'(loc) - 19'(bias);
		lim = $signed({4'b0000, bound}) - 19'sd1;
		if (is_max) begin
			v = d + 19'(BOX_HALF);
			if (v > lim) begin
				v = lim;
			end
		end else begin
			v = d - 19'(BOX_HALF);
		end
		return (v <= 19'sd0) ? '0 : v[DVD_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] sat_cell(input logic [DVD_W-1:0] q);
		return (q > DVD_W'(GRID_CELLS - 1)) ? CELL_W'(GRID_CELLS - 1) : q[CELL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/grid_cell_membership_diff.sv
// ----------------------------------------------------------------------------
// grid_cell_membership_diff
// Keeps the cell rectangle of each tracked object and emits the add and
// remove commands that move its grid membership to a new location or drop it.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  in       input      in_valid / in_stall  opcode, object_id, loc_x, loc_y
//  out      output     out_valid/out_stall  target_object, cell_x, cell_y,
//                                           add_flag, last
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// An update runs through setup (table read, divider, clamp, plan) and then
// emits one word per cycle while the output does not stall, up to 32 words;
// each empty strip slot ahead of the last filled one is shifted out on its own,
// and with no slot filled the block goes idle again. A remove skips the divider.
// Reset clears the valid bits of all 256 table entries at once.
// Output stalls hold the emitter; a new word is taken once the last word of
// the previous one sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_membership_diff import gcmd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    opcode,
	input  wire logic [7:0]              object_id,
	input  wire logic signed [15:0]      loc_x,
	input  wire logic signed [15:0]      loc_y,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [7:0]              target_object,
	output logic      [5:0]              cell_x,
	output logic      [5:0]              cell_y,
	output logic                         add_flag,
	output logic                         last,
	input  wire logic                    cfg_we,
	input  wire logic [IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_CLAMP = 6'b001000,
		ST_PLAN  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;

	logic signed [15:0] bias_x_q, bias_y_q;
	logic [14:0]        bound_x_q, bound_y_q;
	logic [CW_W-1:0]    cell_width_q;

	logic               op_q;
	logic [7:0]         id_q;
	logic signed [15:0] loc_x_q, loc_y_q;
	logic               old_vld_q;
	rect_t              old_q, new_q;
	logic [OBJECTS-1:0] vld_q;
	blk_t               blk_q [4];
	logic [CELL_W-1:0]  x_q, y_q;

	logic               out_valid_q, add_q, last_q;
	logic [7:0]         tobj_q;
	logic [CELL_W-1:0]  cx_q, cy_q;

	logic [RECT_W-1:0]  ram_rdata;
	logic               ram_we;
	logic               div_start;
	logic [CW_W-1:0]    cw_eff;
	logic [DVD_W-1:0]   dvd [4];
	logic [DVD_W-1:0]   quo [4];
	logic [3:0]         div_done;
	blk_t               plan [4];
	logic               out_free, in_acc, obj_ok, blk_end, more, emit_go;
	logic [CELL_W-1:0]  q_sx, q_ex, q_sy, q_ey, cx0, cx1;
	rect_t              p, q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign obj_ok    = int'(id_q) < OBJECTS;
	assign cw_eff    = (cell_width_q < CW_W'(MIN_CW)) ? CW_W'(MIN_CW) : cell_width_q;
	assign div_start = (state_q == ST_READ);
	assign ram_we    = (state_q == ST_PLAN) && (op_q == OP_UPDATE);

	assign dvd[0] = axis_dvd(loc_x_q, bias_x_q, bound_x_q, 1'b0);
	assign dvd[1] = axis_dvd(loc_x_q, bias_x_q, bound_x_q, 1'b1);
	assign dvd[2] = axis_dvd(loc_y_q, bias_y_q, bound_y_q, 1'b0);
	assign dvd[3] = axis_dvd(loc_y_q, bias_y_q, bound_y_q, 1'b1);

	for (genvar i = 0; i < 4; i++) begin : g_div
		gcmd_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (dvd[i]),
			.divisor  (cw_eff),
			.done     (div_done[i]),
			.quotient (quo[i])
		);
	end

	gcmd_ram #(.WIDTH(RECT_W), .DEPTH(OBJECTS)) u_rect_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (OBJ_W'(id_q)),
		.wdata (new_q),
		.raddr (OBJ_W'(object_id)),
		.rdata (ram_rdata)
	);

	always_comb begin
		q_sx = sat_cell(quo[0]);
		q_ex = sat_cell(quo[1]);
		q_sy = sat_cell(quo[2]);
		q_ey = sat_cell(quo[3]);
		if (q_sx > q_ex) begin
			q_sx = q_ex;
		end
		if (q_sy > q_ey) begin
			q_sy = q_ey;
		end
	end

	always_comb begin
		p = old_q;
		q = new_q;
		cx0 = (q.sx > p.sx) ? q.sx : p.sx;
		cx1 = (q.ex < p.ex) ? q.ex : p.ex;
		for (int i = 0; i < 4; i++) begin
			plan[i] = '0;
		end
		if (op_q == OP_REMOVE) begin
			if (old_vld_q) begin
				plan[0] = '{1'b1, 1'b0, p.sx, p.ex, p.sy, p.ey};
			end
		end else if (!old_vld_q) begin
			plan[0] = '{1'b1, 1'b1, q.sx, q.ex, q.sy, q.ey};
		end else if (q.sx > p.ex || q.ex < p.sx || q.sy > p.ey || q.ey < p.sy) begin
			plan[0] = '{1'b1, 1'b0, p.sx, p.ex, p.sy, p.ey};
			plan[1] = '{1'b1, 1'b1, q.sx, q.ex, q.sy, q.ey};
		end else begin
			if (p.sx < q.sx) begin
				plan[0] = '{1'b1, 1'b0, p.sx, q.sx - 1'b1, p.sy, p.ey};
			end else if (p.sx > q.sx) begin
				plan[0] = '{1'b1, 1'b1, q.sx, p.sx - 1'b1, q.sy, q.ey};
			end
			if (p.ex < q.ex) begin
				plan[1] = '{1'b1, 1'b1, p.ex + 1'b1, q.ex, q.sy, q.ey};
			end else if (p.ex > q.ex) begin
				plan[1] = '{1'b1, 1'b0, q.ex + 1'b1, p.ex, p.sy, p.ey};
			end
			if (p.sy < q.sy) begin
				plan[2] = '{1'b1, 1'b0, cx0, cx1, p.sy, q.sy - 1'b1};
			end else if (p.sy > q.sy) begin
				plan[2] = '{1'b1, 1'b1, cx0, cx1, q.sy, p.sy - 1'b1};
			end
			if (p.ey < q.ey) begin
				plan[3] = '{1'b1, 1'b1, cx0, cx1, p.ey + 1'b1, q.ey};
			end else if (p.ey > q.ey) begin
				plan[3] = '{1'b1, 1'b0, cx0, cx1, q.ey + 1'b1, p.ey};
			end
		end
	end

	assign blk_end = (x_q == blk_q[0].x1) && (y_q == blk_q[0].y1);
	assign more    = blk_q[1].en || blk_q[2].en || blk_q[3].en;
	assign emit_go = (state_q == ST_EMIT) && blk_q[0].en && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_q        <= '0;
			out_valid_q  <= 1'b0;
			bias_x_q     <= '0;
			bias_y_q     <= '0;
			bound_x_q    <= 15'd512;
			bound_y_q    <= 15'd512;
			cell_width_q <= 12'd8;
			for (int i = 0; i < 4; i++) begin
				blk_q[i].en <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BIAS_X:     bias_x_q     <= cfg_data;
					REG_BIAS_Y:     bias_y_q     <= cfg_data;
					REG_BOUND_X:    bound_x_q    <= cfg_data[14:0];
					REG_BOUND_Y:    bound_y_q    <= cfg_data[14:0];
					REG_CELL_WIDTH: cell_width_q <= cfg_data[CW_W-1:0];
					default: ;
				endcase
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!obj_ok) begin
						state_q <= ST_IDLE;
					end else if (op_q == OP_REMOVE) begin
						state_q <= ST_PLAN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (&div_done) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					vld_q[OBJ_W'(id_q)] <= (op_q == OP_UPDATE);
					for (int i = 0; i < 4; i++) begin
						blk_q[i] <= plan[i];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!blk_q[0].en) begin
						if (more) begin
							for (int i = 0; i < 3; i++) begin
								blk_q[i] <= blk_q[i+1];
							end
							blk_q[3].en <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (out_free) begin
						if (blk_end) begin
							for (int i = 0; i < 3; i++) begin
								blk_q[i] <= blk_q[i+1];
							end
							blk_q[3].en <= 1'b0;
							if (!more) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= opcode;
			id_q    <= object_id;
			loc_x_q <= loc_x;
			loc_y_q <= loc_y;
		end
		if (state_q == ST_READ) begin
			old_q     <= ram_rdata;
			old_vld_q <= vld_q[OBJ_W'(id_q)];
		end
		if (state_q == ST_CLAMP) begin
			new_q <= '{q_sx, q_sy, q_ex, q_ey};
		end
		if (state_q == ST_PLAN) begin
			x_q <= plan[0].x0;
			y_q <= plan[0].y0;
		end
		if (state_q == ST_EMIT) begin
			if (!blk_q[0].en) begin
				x_q <= blk_q[1].x0;
				y_q <= blk_q[1].y0;
			end else if (out_free) begin
				tobj_q <= id_q;
				cx_q   <= x_q;
				cy_q   <= y_q;
				add_q  <= blk_q[0].add;
				last_q <= blk_end && !more;
				if (x_q != blk_q[0].x1) begin
					x_q <= x_q + 1'b1;
				end else if (y_q != blk_q[0].y1) begin
					x_q <= blk_q[0].x0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= blk_q[1].x0;
					y_q <= blk_q[1].y0;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign target_object = tobj_q;
	assign cell_x        = cx_q;
	assign cell_y        = cy_q;
	assign add_flag      = add_q;
	assign last          = last_q;

endmodule

`default_nettype wire

// File: rtl/gcmd_ram.sv
// ----------------------------------------------------------------------------
// gcmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/gcmd_div.sv
// ----------------------------------------------------------------------------
// gcmd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmd_div import gcmd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [CW_W-1:0]  divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [CW_W:0]    rem_q;
	logic [CW_W-1:0]  dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CW_W:0]    rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[CW_W-1:0], dvd_q[DVD_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// File: rtl/gcmd_checker.sv
// ----------------------------------------------------------------------------
// gcmd_checker
// Port-level checks of the grid cell membership update block.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  target_object,
	input wire logic [5:0]  cell_x,
	input wire logic [5:0]  cell_y,
	input wire logic        add_flag,
	input wire logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(cell_x) && $stable(cell_y)
			&& $stable(add_flag) && $stable(last) && $stable(target_object)))
		else $error("Stalled output word changed.");

	a_one_word_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("Input taken while a word is still in work.");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({target_object, cell_x, cell_y, add_flag, last}))
		else $error("Output word carries unknown bits.");

	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_stall) |-> last)
		else $error("Block ready while a non-final word is pending.");

endmodule

bind grid_cell_membership_diff gcmd_checker u_gcmd_checker (.*);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of grid_cell_membership_diff. It predicts the cell
// add and remove words of every accepted update or remove, compares each
// output word field by field, and runs several register settings with
// bursty input traffic and random output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import gcmd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   LIMIT_CYCLES = 1500000;

	typedef struct packed {
		logic [7:0] obj;
		logic [5:0] x;
		logic [5:0] y;
		logic       add;
		logic       last;
	} cmd_t;

	typedef struct {
		bit valid;
		int sx, sy, ex, ey;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_UPDATE;
	logic [7:0] object_id = '0;
	logic signed [15:0] loc_x = '0;
	logic signed [15:0] loc_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] target_object;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic add_flag;
	logic last;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int   m_bias_x, m_bias_y, m_bound_x, m_bound_y, m_cell_w;
	box_t boxes[256];
	cmd_t pending_cmds[$];
	cmd_t new_cmds[$];
	int   errors = 0;
	int   cycles = 0;
	int   burst_left = 0;
	bit   noisy_out = 1'b1;

	grid_cell_membership_diff dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (noisy_out)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cmd_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{target_object, cell_x, cell_y, add_flag, last};
			if (pending_cmds.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				if (got.obj !== want.obj)
					$display("%0t object: expected %0d actual %0d", $time, want.obj, got.obj);
				if (got.x !== want.x)
					$display("%0t cell_x: expected %0d actual %0d", $time, want.x, got.x);
				if (got.y !== want.y)
					$display("%0t cell_y: expected %0d actual %0d", $time, want.y, got.y);
				if (got.add !== want.add)
					$display("%0t add_flag: expected %0b actual %0b", $time, want.add, got.add);
				if (got.last !== want.last)
					$display("%0t last: expected %0b actual %0b", $time, want.last, got.last);
				if (got !== want)
					errors++;
			end
		end
	end

	function automatic int cell_of(int v, int cw);
		int c;
		c = (v <= 0) ? 0 : v / cw;
		return (c > GRID_CELLS - 1) ? GRID_CELLS - 1 : c;
	endfunction

	task automatic axis_cells(input int loc, input int bias, input int bound, input int cw,
			output int s, output int e);
		int d, hi;
		d = loc - bias;
		hi = d + BOX_HALF;
		if (hi > bound - 1)
			hi = bound - 1;
		s = cell_of(d - BOX_HALF, cw);
		e = cell_of(hi, cw);
		if (s > e)
			s = e;
	endtask

	task automatic push_block(input int obj, input int x0, input int x1, input int y0,
			input int y1, input bit add);
		for (int y = y0; y <= y1; y++)
			for (int x = x0; x <= x1; x++)
				if (new_cmds.size() < 32)
					new_cmds.insert(new_cmds.size(), '{8'(obj), 6'(x), 6'(y), add, 1'b0});
	endtask

	task automatic predict_cmds(input logic op, input int obj, input int lx, input int ly);
		box_t p, q;
		int cw, cx0, cx1;
		new_cmds.delete();
		p = boxes[obj];
		if (op == OP_REMOVE) begin
			if (p.valid) begin
				push_block(obj, p.sx, p.ex, p.sy, p.ey, 1'b0);
				boxes[obj].valid = 1'b0;
			end
		end else begin
			cw = (m_cell_w < MIN_CW) ? MIN_CW : m_cell_w;
			q.valid = 1'b1;
			axis_cells(lx, m_bias_x, m_bound_x, cw, q.sx, q.ex);
			axis_cells(ly, m_bias_y, m_bound_y, cw, q.sy, q.ey);
			if (!p.valid) begin
				push_block(obj, q.sx, q.ex, q.sy, q.ey, 1'b1);
			end else if (q.sx > p.ex || q.ex < p.sx || q.sy > p.ey || q.ey < p.sy) begin
				push_block(obj, p.sx, p.ex, p.sy, p.ey, 1'b0);
				push_block(obj, q.sx, q.ex, q.sy, q.ey, 1'b1);
			end else begin
				if (p.sx < q.sx)
					push_block(obj, p.sx, q.sx - 1, p.sy, p.ey, 1'b0);
				else if (p.sx > q.sx)
					push_block(obj, q.sx, p.sx - 1, q.sy, q.ey, 1'b1);
				if (p.ex < q.ex)
					push_block(obj, p.ex + 1, q.ex, q.sy, q.ey, 1'b1);
				else if (p.ex > q.ex)
					push_block(obj, q.ex + 1, p.ex, p.sy, p.ey, 1'b0);
				cx0 = (q.sx > p.sx) ? q.sx : p.sx;
				cx1 = (q.ex < p.ex) ? q.ex : p.ex;
				if (p.sy < q.sy)
					push_block(obj, cx0, cx1, p.sy, q.sy - 1, 1'b0);
				else if (p.sy > q.sy)
					push_block(obj, cx0, cx1, q.sy, p.sy - 1, 1'b1);
				if (p.ey < q.ey)
					push_block(obj, cx0, cx1, p.ey + 1, q.ey, 1'b1);
				else if (p.ey > q.ey)
					push_block(obj, cx0, cx1, q.ey + 1, p.ey, 0);
			end
			boxes[obj] = q;
		end
		if (new_cmds.size() > 0)
			new_cmds[new_cmds.size() - 1].last = 1'b1;
		foreach (new_cmds[i])
			pending_cmds.insert(pending_cmds.size(), new_cmds[i]);
	endtask

	task automatic send_word(input logic op, input int obj, input int lx, input int ly);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		opcode <= op;
		object_id <= 8'(obj);
		loc_x <= 16'(lx);
		loc_y <= 16'(ly);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_cmds(op, obj, 16'sh0 + $signed(16'(lx)), $signed(16'(ly)));
		burst_left--;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		case (idx)
			REG_BIAS_X: m_bias_x = $signed(16'(val));
			REG_BIAS_Y: m_bias_y = $signed(16'(val));
			REG_BOUND_X: m_bound_x = val & 16'h7fff;
			REG_BOUND_Y: m_bound_y = val & 16'h7fff;
			REG_CELL_WIDTH: m_cell_w = val & 16'h0fff;
			default: ;
		endcase
	endtask

	task automatic set_all(input int bx, input int by, input int ux, input int uy, input int cw);
		write_reg(REG_BIAS_X, bx);
		write_reg(REG_BIAS_Y, by);
		write_reg(REG_BOUND_X, ux);
		write_reg(REG_BOUND_Y, uy);
		write_reg(REG_CELL_WIDTH, cw);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed;
		send_word(OP_REMOVE, 3, 0, 0);
		send_word(OP_UPDATE, 0, 0, 0);
		send_word(OP_UPDATE, 0, 0, 0);
		send_word(OP_UPDATE, 0, 6, 3);
		send_word(OP_UPDATE, 0, 2, 12);
		send_word(OP_UPDATE, 0, 200, 200);
		send_word(OP_UPDATE, 255, 32767, 32767);
		send_word(OP_UPDATE, 255, -32768, -32768);
		send_word(OP_UPDATE, 255, 511, 0);
		send_word(OP_REMOVE, 255, 0, 0);
		send_word(OP_REMOVE, 255, 0, 0);
		send_word(OP_UPDATE, 128, 100, 100);
		send_word(OP_UPDATE, 128, 108, 92);
		send_word(OP_UPDATE, 128, 92, 108);
		send_word(OP_REMOVE, 128, 0, 0);
		send_word(OP_REMOVE, 0, -1, -1);
		drain();
	endtask

	task automatic test_settings;
		set_all(-32768, 32767, 1, 32767, 4095);
		send_word(OP_UPDATE, 5, 32767, -32768);
		send_word(OP_UPDATE, 5, -32768, 32767);
		send_word(OP_REMOVE, 5, 0, 0);
		drain();
		set_all(32767, -32768, 32767, 1, 7);
		send_word(OP_UPDATE, 6, -1, 300);
		send_word(OP_UPDATE, 6, 0, 0);
		drain();
		set_all(16, -16, 100, 60, 3);
		send_word(OP_UPDATE, 7, 40, 20);
		send_word(OP_UPDATE, 7, 45, 26);
		drain();
		set_all(0, 0, 0, 0, 0);
		send_word(OP_UPDATE, 8, 40, 20);
		send_word(OP_REMOVE, 8, 0, 0);
		drain();
	endtask

	task automatic test_random(input int count);
		int obj, lx, ly, k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 9);
			obj = $urandom_range(0, 15);
			if (k == 0)
				obj = $urandom_range(0, 255);
			if (k < 2) begin
				lx = $signed(16'($urandom));
				ly = $signed(16'($urandom));
			end else if (boxes[obj].valid && k < 8) begin
				lx = m_bias_x + (boxes[obj].sx + 1) * m_cell_w + $urandom_range(0, 40) - 20;
				ly = m_bias_y + (boxes[obj].sy + 1) * m_cell_w + $urandom_range(0, 40) - 20;
			end else begin
				lx = m_bias_x + $urandom_range(0, 600) - 40;
				ly = m_bias_y + $urandom_range(0, 600) - 40;
			end
			send_word((k == 9) ? OP_REMOVE : OP_UPDATE, obj, lx, ly);
		end
		drain();
	endtask

	initial begin
		m_bias_x = 0;
		m_bias_y = 0;
		m_bound_x = 512;
		m_bound_y = 512;
		m_cell_w = 8;
		foreach (boxes[i])
			boxes[i] = '{1'b0, 0, 0, 0, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		set_all(0, 0, 512, 512, 8);
		noisy_out = 1'b0;
		test_random(100);
		noisy_out = 1'b1;
		set_all(-200, 300, 400, 300, 12);
		test_random(150);
		set_all(1000, -1000, 700, 500, 9);
		test_random(150);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
